// ===== sv/text_to_page_framebuffer_writer_assert.svh =====
// Assertion macros for the text-to-page frame buffer writer.
// Used by the top level only; no other dependencies.
`ifndef TEXT_TO_PAGE_FRAMEBUFFER_WRITER_ASSERT_SVH
`define TEXT_TO_PAGE_FRAMEBUFFER_WRITER_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked property, off while reset is high.
`define TPFW_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tpfw assertion failed");
// Checked property, also evaluated during reset.
`define TPFW_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("tpfw reset assertion failed");
`else
`define TPFW_ASSERT(lbl, prop)
`define TPFW_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== sv/tpfw_pkg.sv =====
// Package for the text-to-page frame buffer writer: codes, font table,
// job type and the address and pixel byte functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tpfw_pkg;

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_WIDE   = 2'd1;
   localparam logic [1:0] MODE_BIG    = 2'd2;

   localparam logic [7:0] CHAR_NEWLINE = 8'h7C;
   localparam logic [7:0] CHAR_SCALE1  = 8'h31;
   localparam logic [7:0] CHAR_SCALE2  = 8'h32;
   localparam logic [7:0] CHAR_SCALE4  = 8'h34;
   localparam logic [7:0] CHAR_FIRST   = 8'h20;
   localparam logic [7:0] CHAR_LAST    = 8'h7E;

   localparam int          MAX_WRITES = 20;
   localparam logic [11:0] POS_MAX    = 12'd4095;
   localparam logic [4:0]  LINE_MAX   = 5'd31;

   // One glyph to a row, column 0 in the top byte.
   localparam logic [39:0] FONT_ROM [95] = '{
      40'h0000000000, 40'h00005F0000, 40'h0003000300, 40'h143E143E14,
      40'h242A7F2A12, 40'h4333086661, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h0004027F00, 40'h4261514946, 40'h2241494936,
      40'h1814127F10, 40'h2745454539, 40'h3E49494932, 40'h0101710907,
      40'h3649494936, 40'h264949493E, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h3E4159555E, 40'h7E0909097E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E4141493A,
      40'h7F0808087F, 40'h00417F4100, 40'h304040403F, 40'h7F08142241,
      40'h7F40404040, 40'h7F020C027F, 40'h7F0204087F, 40'h3E4141413E,
      40'h7F09090906, 40'h1E2121215E, 40'h7F09090976, 40'h2649494932,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2010207F,
      40'h41221C2241, 40'h0708700807, 40'h6151494543, 40'h007F410000,
      40'h0204081020, 40'h0000417F00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7F44444438, 40'h3844444444,
      40'h384444447F, 40'h3854545418, 40'h04047E0505, 40'h085454543C,
      40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
      40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414147C, 40'h007C080404, 40'h4854545420,
      40'h04043F4444, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
      40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364141,
      40'h00007F0000, 40'h4141360800, 40'h0201020402
   };

   // One character's pending writes, handed from decode to the emitter.
   typedef struct packed {
      logic [11:0] pos;
      logic [1:0]  mode;
      logic [39:0] glyph;
      logic [19:0] mask;
   } job_type;

   // Glyph of a character; codes outside the printable range are blank.
   function automatic logic [39:0] font_glyph(input logic [7:0] ch);
      logic [6:0] idx;
      idx = 7'(ch - CHAR_FIRST);
      if (ch < CHAR_FIRST || ch > CHAR_LAST) begin
         return 40'd0;
      end
      return FONT_ROM[idx];
   endfunction

   // Each bit of a nibble doubled into a pair of bits.
   function automatic logic [7:0] stretch_nibble(input logic [3:0] nib);
      return {nib[3], nib[3], nib[2], nib[2], nib[1], nib[1], nib[0], nib[0]};
   endfunction

   // Number of writes a glyph takes in a scale mode.
   function automatic logic [4:0] write_count(input logic [1:0] mode);
      unique case (mode)
         MODE_WIDE: return 5'd10;
         MODE_BIG:  return 5'd20;
         default:   return 5'd5;
      endcase
   endfunction

   // Byte address of write k of a glyph at position p.
   function automatic logic [12:0] write_addr(input logic [11:0] p,
                                              input logic [1:0]  mode,
                                              input logic [4:0]  k,
                                              input logic [8:0]  row);
      logic [12:0] base;
      base = {1'b0, p};
      unique case (mode)
         MODE_BIG: return base + 13'({k[4:2], 1'b0}) + 13'(k[0])
                          + (k[1] ? {4'd0, row} : 13'd0);
         default:  return base + 13'(k);
      endcase
   endfunction

   // Pixel byte of write k of a glyph.
   function automatic logic [7:0] write_byte(input logic [39:0] glyph,
                                             input logic [1:0]  mode,
                                             input logic [4:0]  k);
      logic [2:0] col;
      logic [7:0] g;
      unique case (mode)
         MODE_WIDE: col = k[3:1];
         MODE_BIG:  col = k[4:2];
         default:   col = k[2:0];
      endcase
      g = glyph[(32 - 8 * int'(col)) +: 8];
      if (mode == MODE_BIG) begin
         return k[1] ? stretch_nibble(g[7:4]) : stretch_nibble(g[3:0]);
      end
      return g;
   endfunction

endpackage
`default_nettype wire

// ===== sv/tpfw_decode.sv =====
// Character decoder: keeps position, column, line and scale, and builds the
// write job for each character. Depends on tpfw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpfw_decode #(
   parameter int ROW_BYTES   = 128,
   parameter int FRAME_BYTES = 2048
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              consume,
   input  wire logic [7:0]        char_code,
   input  wire logic              new_text,
   output tpfw_pkg::job_type      job
);
   localparam int COL_W = $clog2(ROW_BYTES);
   localparam logic [COL_W-1:0] SAT_COL = COL_W'(4095 % ROW_BYTES);
   localparam logic [COL_W:0]   ROW_C   = (COL_W+1)'(ROW_BYTES);
   localparam logic [8:0]       ROW_9   = 9'(ROW_BYTES);
   localparam logic [12:0]      FRAME_C = 13'(FRAME_BYTES);

   logic [11:0]      pos_ff, pos_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [4:0]       line_ff, line_in;
   logic [1:0]       mode_ff, mode_in;

   logic [11:0]      p;
   logic [COL_W-1:0] col;
   logic [4:0]       line, line_next;
   logic [1:0]       mode;
   logic             is_newline, is_scale;
   logic [13:0]      row_start_pos;
   logic [3:0]       step;
   logic [12:0]      sum;
   logic [COL_W:0]   col_sum;
   logic [4:0]       count;
   logic [19:0]      mask;

   // A new string starts from the reset state.
   always_comb begin
      p    = new_text ? 12'd0 : pos_ff;
      col  = new_text ? '0 : col_ff;
      line = new_text ? 5'd0 : line_ff;
      mode = new_text ? tpfw_pkg::MODE_NORMAL : mode_ff;
   end

   // Character class and next position.
   always_comb begin
      is_newline = (char_code == tpfw_pkg::CHAR_NEWLINE);
      is_scale   = (col == '0) && (char_code == tpfw_pkg::CHAR_SCALE1 ||
                   char_code == tpfw_pkg::CHAR_SCALE2 ||
                   char_code == tpfw_pkg::CHAR_SCALE4);
      line_next     = (line == tpfw_pkg::LINE_MAX) ? line : line + 5'd1;
      row_start_pos = 14'(line_next) * 14'(ROW_BYTES);
      if (is_scale) begin
         step = 4'd1;
      end else if (mode == tpfw_pkg::MODE_WIDE || mode == tpfw_pkg::MODE_BIG) begin
         step = 4'd11;
      end else begin
         step = 4'd6;
      end
      sum     = {1'b0, p} + 13'(step);
      col_sum = {1'b0, col} + (COL_W+1)'(step);

      line_in = line;
      mode_in = mode;
      if (is_newline) begin
         line_in = line_next;
         if (row_start_pos > 14'(tpfw_pkg::POS_MAX)) begin
            pos_in = tpfw_pkg::POS_MAX;
            col_in = SAT_COL;
         end else begin
            pos_in = row_start_pos[11:0];
            col_in = '0;
         end
      end else begin
         if (is_scale) begin
            if (char_code == tpfw_pkg::CHAR_SCALE1) begin
               mode_in = tpfw_pkg::MODE_NORMAL;
            end else if (char_code == tpfw_pkg::CHAR_SCALE2) begin
               mode_in = tpfw_pkg::MODE_WIDE;
            end else begin
               mode_in = tpfw_pkg::MODE_BIG;
            end
         end
         if (sum > 13'(tpfw_pkg::POS_MAX)) begin
            pos_in = tpfw_pkg::POS_MAX;
            col_in = SAT_COL;
         end else begin
            pos_in = sum[11:0];
            col_in = (col_sum >= ROW_C) ? COL_W'(col_sum - ROW_C) : COL_W'(col_sum);
         end
      end
   end

   // Writes that land inside the frame.
   always_comb begin
      count = tpfw_pkg::write_count(mode);
      for (int k = 0; k < tpfw_pkg::MAX_WRITES; k++) begin
         mask[k] = !is_newline && !is_scale && (5'(k) < count) &&
                   (tpfw_pkg::write_addr(p, mode, 5'(k), ROW_9) < FRAME_C);
      end
      job.pos   = p;
      job.mode  = mode;
      job.glyph = tpfw_pkg::font_glyph(char_code);
      job.mask  = mask;
   end

   // Text state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         col_ff  <= '0;
         line_ff <= '0;
         mode_ff <= tpfw_pkg::MODE_NORMAL;
      end else if (consume) begin
         pos_ff  <= pos_in;
         col_ff  <= col_in;
         line_ff <= line_in;
         mode_ff <= mode_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/tpfw_emit.sv =====
// Write emitter: holds one job and, unless the output stalls, sends one frame
// buffer write per cycle through the result register. Depends on tpfw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpfw_emit #(
   parameter int ROW_BYTES = 128
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   input  wire tpfw_pkg::job_type job,
   output logic                   job_free,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [23:0]            rsp_tdata,
   output logic                   rsp_tlast
);
   localparam logic [8:0] ROW_9 = 9'(ROW_BYTES);

   logic [11:0] pos_ff, pos_in;
   logic [1:0]  mode_ff, mode_in;
   logic [39:0] glyph_ff, glyph_in;
   logic [19:0] mask_ff, mask_in;
   logic        valid_ff, valid_in;
   logic [23:0] data_ff, data_in;
   logic        last_ff, last_in;
   logic        out_adv, emit_go;
   logic [4:0]  idx;
   logic [12:0] addr;

   // Lowest pending write goes first.
   always_comb begin
      idx = 5'd0;
      for (int i = tpfw_pkg::MAX_WRITES - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            idx = 5'(i);
         end
      end
      out_adv  = !valid_ff || rsp_tready;
      emit_go  = out_adv && (mask_ff != '0);
      job_free = (mask_ff == '0) || (emit_go && $onehot(mask_ff));
      addr     = tpfw_pkg::write_addr(pos_ff, mode_ff, idx, ROW_9);
   end

   // Job registers and result register next values.
   always_comb begin
      pos_in   = pos_ff;
      mode_in  = mode_ff;
      glyph_in = glyph_ff;
      mask_in  = mask_ff;
      if (job_valid && job_free) begin
         pos_in   = job.pos;
         mode_in  = job.mode;
         glyph_in = job.glyph;
         mask_in  = job.mask;
      end else if (emit_go) begin
         mask_in = mask_ff & (mask_ff - 20'd1);
      end
      valid_in = out_adv ? emit_go : valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (emit_go) begin
         data_in = {5'd0, tpfw_pkg::write_byte(glyph_ff, mode_ff, idx), addr[10:0]};
         last_in = $onehot(mask_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      mode_ff  <= mode_in;
      glyph_ff <= glyph_in;
      data_ff  <= data_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
endmodule
`default_nettype wire

// ===== sv/text_to_page_framebuffer_writer.sv =====
// Draws text into a page-organized monochrome frame buffer with a 5x7 font,
// one character per input transaction and one byte write per output
// transaction. A character is decoded in the cycle it leaves the input
// register, which overlaps the last write of the previous character; the
// emitter then makes 5 byte writes in normal size, 10 in double width and 20
// in double size, fewer where writes fall past the frame end. A character
// that causes no write (a newline, a scale select, or a glyph wholly past
// the frame end) still passes through the emitter's job registers. When the
// emitter is free, the first write of a character goes from the input
// register through the job registers to the result register. The emitter
// sets the rate: one write per cycle unless the output stalls.
// Depends on tpfw_pkg, tpfw_decode, tpfw_emit and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "text_to_page_framebuffer_writer_assert.svh"
module text_to_page_framebuffer_writer #(
   parameter int ROW_BYTES   = 128,
   parameter int FRAME_BYTES = 2048
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic        req_tuser,   // [0] new_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [10:0] write_addr, [18:11] write_byte, rest 0
   output logic             rsp_tlast    // last_write
);
   logic              in_valid_ff, in_valid_in;
   logic [7:0]        char_ff, char_in;
   logic              new_ff, new_in;
   logic              job_free, consume;
   tpfw_pkg::job_type job;

   // Input register; it refills in the cycle its character is taken.
   always_comb begin
      consume     = in_valid_ff && job_free;
      req_tready  = !in_valid_ff || consume;
      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
      char_in     = (req_tvalid && req_tready) ? req_tdata : char_ff;
      new_in      = (req_tvalid && req_tready) ? req_tuser : new_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      new_ff  <= new_in;
   end

   tpfw_decode #(
      .ROW_BYTES   (ROW_BYTES),
      .FRAME_BYTES (FRAME_BYTES)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .consume   (consume),
      .char_code (char_ff),
      .new_text  (new_ff),
      .job       (job)
   );

   tpfw_emit #(
      .ROW_BYTES (ROW_BYTES)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (in_valid_ff),
      .job        (job),
      .job_free   (job_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A character waiting on a busy emitter stays in the input register.
   `TPFW_ASSERT(a_hold_waiting, in_valid_ff && !job_free |=> in_valid_ff && $stable(char_ff))
   // Nothing is offered in the cycle after reset.
   `TPFW_ASSERT_RST(a_reset_quiet, reset |=> !rsp_tvalid && !in_valid_ff)
endmodule
`default_nettype wire
